// ----- rtl/base64_stream_decoder_unit_assert.svh -----
// Assertion helpers shared by the decoder modules.
// Both macros sample on clk and are disabled while rst is high.
`ifndef BASE64_STREAM_DECODER_UNIT_ASSERT_SVH
`define BASE64_STREAM_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define B64D_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("b64d assertion failed");

// Next-cycle implication.
`define B64D_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("b64d assertion failed");

`endif

// ----- rtl/b64d_pkg.sv -----
`default_nettype none
package b64d_pkg;

  // Status codes carried on the final result of a text
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [1:0] ST_BAD_LEN  = 2'd2;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Sextet code for a character that is not in the alphabet
  localparam logic [6:0] NO_SEXTET = 7'd64;

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  // One queue entry: the bytes of a finished group and/or the text status
  typedef struct packed {
    logic [23:0] group_bits;
    logic [1:0]  nbytes;
    logic        has_status;
    logic [1:0]  status;
  } entry_t;

  // Queue fill flags seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_flags_t;

  // Map one character to its base64 value, NO_SEXTET if outside the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    v = NO_SEXTET;
    if (c inside {[8'h41:8'h5A]}) begin
      v = 7'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      v = 7'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      v = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      v = 7'd62;
    end else if (c == 8'h2F) begin
      v = 7'd63;
    end
    return v;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c inside {[8'h09:8'h0D]});
  endfunction

endpackage
`default_nettype wire

// ----- rtl/b64d_front.sv -----
`default_nettype none
`include "base64_stream_decoder_unit_assert.svh"
module b64d_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire b64d_pkg::in_item_t in_data,
  input  wire b64d_pkg::q_flags_t q_flags,
  output logic                   push,
  output b64d_pkg::entry_t       push_entry
);
  import b64d_pkg::*;

  logic        strip_prefix;
  logic [23:0] group_bits, group_bits_next;
  logic [1:0]  group_position, group_position_next;
  logic [1:0]  pad_seen, pad_seen_next;
  logic        past_prefix, past_prefix_next;
  logic        error_code, error_code_next;

  logic       accept;
  logic [7:0] c;
  logic [6:0] v;
  logic       pad;
  logic       bad;
  logic       emit_bytes;

  assign in_stall = q_flags.full;
  assign accept   = in_valid && !in_stall;

  // Classify the character and advance the group state
  always_comb begin
    c   = in_data.text_char;
    v   = sextet_of(c);
    pad = (c == CHAR_PAD);
    bad = 1'b0;
    emit_bytes = 1'b0;

    group_bits_next     = group_bits;
    group_position_next = group_position;
    pad_seen_next       = pad_seen;
    past_prefix_next    = past_prefix;
    error_code_next     = error_code;

    push_entry = '0;

    if (accept) begin
      if (strip_prefix && !past_prefix) begin
        if (c == CHAR_COMMA) begin
          past_prefix_next = 1'b1;
        end
      end else if (!error_code && !is_blank(c)) begin
        if (pad_seen != 2'd0 && group_position == 2'd0) begin
          bad = 1'b1;  // anything after a padded group
        end else if (pad) begin
          if (group_position < 2'd2) begin
            bad = 1'b1;  // pad too early in the group
          end else begin
            v = 7'd0;
          end
        end else if (v == NO_SEXTET || pad_seen != 2'd0) begin
          bad = 1'b1;
        end

        if (bad) begin
          error_code_next = 1'b1;
        end else begin
          if (pad) begin
            pad_seen_next = pad_seen + 2'd1;
          end
          group_bits_next = {group_bits[17:0], v[5:0]};
          if (group_position == 2'd3) begin
            emit_bytes            = 1'b1;
            push_entry.group_bits = group_bits_next;
            if (pad_seen_next == 2'd0) begin
              push_entry.nbytes = 2'd3;
            end else if (pad_seen_next == 2'd1) begin
              push_entry.nbytes = 2'd2;
            end else begin
              push_entry.nbytes = 2'd1;
            end
            group_bits_next     = '0;
            group_position_next = 2'd0;
          end else begin
            group_position_next = group_position + 2'd1;
          end
        end
      end

      // End of text: report status and clear the per-text state
      if (in_data.end_of_text) begin
        push_entry.has_status = 1'b1;
        if (error_code_next) begin
          push_entry.status = ST_BAD_CHAR;
        end else if (group_position_next != 2'd0) begin
          push_entry.status = ST_BAD_LEN;
        end else begin
          push_entry.status = ST_OK;
        end
        group_bits_next     = '0;
        group_position_next = 2'd0;
        pad_seen_next       = 2'd0;
        past_prefix_next    = 1'b0;
        error_code_next     = 1'b0;
      end
    end

    push = accept && (emit_bytes || in_data.end_of_text);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strip_prefix   <= 1'b0;
      group_bits     <= '0;
      group_position <= 2'd0;
      pad_seen       <= 2'd0;
      past_prefix    <= 1'b0;
      error_code     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        strip_prefix <= cfg_data;
      end
      group_bits     <= group_bits_next;
      group_position <= group_position_next;
      pad_seen       <= pad_seen_next;
      past_prefix    <= past_prefix_next;
      error_code     <= error_code_next;
    end
  end

  // A finished text leaves the decoder clean for the next one
  `B64D_ASSERT_NEXT(a_eot_clears, accept && in_data.end_of_text,
                    group_position == 2'd0 && !error_code && pad_seen == 2'd0)
  // An error entry never carries bytes
  `B64D_ASSERT_NOW(a_err_no_bytes, push && error_code, push_entry.nbytes == 2'd0)

endmodule
`default_nettype wire

// ----- rtl/b64d_queue.sv -----
`default_nettype none
`include "base64_stream_decoder_unit_assert.svh"
module b64d_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire b64d_pkg::entry_t push_entry,
  input  wire logic             pop,
  output b64d_pkg::entry_t      head,
  output b64d_pkg::q_flags_t    q_flags
);
  import b64d_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t        slots [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign head          = slots[rptr];
  assign q_flags.full  = (count == FULL_CNT);
  assign q_flags.empty = (count == '0);

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `B64D_ASSERT_NOW(a_no_overflow, push, !q_flags.full || pop)
  `B64D_ASSERT_NOW(a_no_underflow, pop, !q_flags.empty)

endmodule
`default_nettype wire

// ----- rtl/b64d_back.sv -----
`default_nettype none
`include "base64_stream_decoder_unit_assert.svh"
module b64d_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire b64d_pkg::entry_t   head,
  input  wire b64d_pkg::q_flags_t q_flags,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output b64d_pkg::out_item_t     out_data
);
  import b64d_pkg::*;

  logic [1:0] sub;  // result index within the head entry
  logic       load;
  logic       emit;
  logic       end_of_entry;
  out_item_t  res;

  assign load = !out_valid || !out_stall;
  assign emit = load && !q_flags.empty;
  assign pop  = emit && end_of_entry;

  // Pick the result that the head entry owes next
  always_comb begin
    res = '0;
    if (sub < head.nbytes) begin
      res.has_byte = 1'b1;
      case (sub)
        2'd0:    res.data_byte = head.group_bits[23:16];
        2'd1:    res.data_byte = head.group_bits[15:8];
        default: res.data_byte = head.group_bits[7:0];
      endcase
      end_of_entry = ({1'b0, sub} + 3'd1 == {1'b0, head.nbytes}) && !head.has_status;
    end else begin
      res.status   = head.status;
      res.last     = 1'b1;
      end_of_entry = 1'b1;
    end
  end

  // Output register and result counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 2'd0;
    end else if (load) begin
      out_valid <= !q_flags.empty;
      if (emit) begin
        sub <= pop ? 2'd0 : sub + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= res;
    end
  end

  // A status result closes the text
  `B64D_ASSERT_NOW(a_status_is_last, out_valid && !out_data.has_byte, out_data.last)

endmodule
`default_nettype wire

// ----- rtl/base64_stream_decoder_unit.sv -----
`default_nettype none
// Streaming base64 decoder. One text character is taken per request, every
// cycle while in_stall is low, and decoded results leave one per cycle through
// a registered output while out_stall is low: one request per byte of each
// completed group of four characters, then one status request (last = 1) for
// the character marked end_of_text. The front classifies characters and
// assembles groups at one character per cycle; the back serializes each
// group's one to three bytes, so input stalls only when the QUEUE_DEPTH-entry
// queue between them fills, which happens when the output is stalled or a run
// of groups yields more results than characters. The user writes strip_prefix
// (cfg_data) only while the block is idle; the block itself does not enforce
// it. cfg_ready is always high. No initialization pass follows reset.
module base64_stream_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire b64d_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output b64d_pkg::out_item_t      out_data
);
  import b64d_pkg::*;

  logic     push;
  logic     pop;
  entry_t   push_entry;
  entry_t   head;
  q_flags_t q_flags;

  assign cfg_ready = 1'b1;

  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_flags    (q_flags),
    .push       (push),
    .push_entry (push_entry)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_flags    (q_flags)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_flags   (q_flags),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
